FILE: rtl/rau_pkg.sv
// ----------------------------------------------------------------------------
// rau_pkg: shared types and codes for the rational arithmetic unit
// Request and result payloads, opcodes, status codes, unit status.
// ----------------------------------------------------------------------------
`default_nettype none

package rau_pkg;

  localparam int DefWidth = 32;

  localparam logic [3:0] OP_ADD = 4'd0;
  localparam logic [3:0] OP_SUB = 4'd1;
  localparam logic [3:0] OP_MUL = 4'd2;
  localparam logic [3:0] OP_DIV = 4'd3;
  localparam logic [3:0] OP_EQ  = 4'd4;
  localparam logic [3:0] OP_LT  = 4'd5;
  localparam logic [3:0] OP_LE  = 4'd6;
  localparam logic [3:0] OP_GT  = 4'd7;
  localparam logic [3:0] OP_GE  = 4'd8;
  localparam logic [3:0] OP_NEG = 4'd9;
  localparam logic [3:0] OP_REC = 4'd10;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DIVZ = 2'd1;
  localparam logic [1:0] ST_OVF  = 2'd2;

  typedef struct packed {
    logic [3:0]         opcode;
    logic signed [31:0] a_num;
    logic signed [31:0] a_den;
    logic signed [31:0] b_num;
    logic signed [31:0] b_den;
  } in_t;

  typedef struct packed {
    logic signed [31:0] res_num;
    logic [30:0]        res_den;
    logic               cmp_true;
    logic [1:0]         status;
  } out_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

endpackage

`default_nettype wire

FILE: rtl/rau_mul.sv
// ----------------------------------------------------------------------------
// rau_mul: registered 32x32 unsigned multiplier
// Shared by all product terms; product appears in the cycle after the operands.
// ----------------------------------------------------------------------------
`default_nettype none

module rau_mul (
  input  wire logic        clk_i,
  input  wire logic [31:0] a_i,
  input  wire logic [31:0] b_i,
  output logic      [63:0] p_o
);

  logic [63:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= {32'd0, a_i} * {32'd0, b_i};
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

FILE: rtl/rau_gcd.sv
// ----------------------------------------------------------------------------
// rau_gcd: iterative binary gcd
// One shift or subtract per cycle; y must be nonzero.
// ----------------------------------------------------------------------------
`default_nettype none

module rau_gcd (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  input  wire logic [63:0]         x_i,
  input  wire logic [63:0]         y_i,
  output rau_pkg::unit_sts_t       sts_o,
  output logic      [63:0]         g_o
);

  logic        busy_q, busy_d;
  logic [63:0] x_q, x_d, y_q, y_d;
  logic [5:0]  k_q, k_d;
  logic        fin;

  assign fin = busy_q && (x_q == 64'd0);

  always_comb begin
    busy_d = busy_q;
    x_d    = x_q;
    y_d    = y_q;
    k_d    = k_q;
    if (start_i && !busy_q) begin
      busy_d = 1'b1;
      x_d    = x_i;
      y_d    = y_i;
      k_d    = 6'd0;
    end else if (busy_q) begin
      if (fin) begin
        busy_d = 1'b0;
      end else if (!x_q[0] && !y_q[0]) begin
        x_d = x_q >> 1;
        y_d = y_q >> 1;
        k_d = k_q + 6'd1;
      end else if (!x_q[0]) begin
        x_d = x_q >> 1;
      end else if (!y_q[0]) begin
        y_d = y_q >> 1;
      end else if (x_q >= y_q) begin
        x_d = x_q - y_q;
      end else begin
        y_d = y_q - x_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    k_q <= k_d;
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = fin;
  assign g_o        = y_q << k_q;

endmodule

`default_nettype wire

FILE: rtl/rau_div.sv
// ----------------------------------------------------------------------------
// rau_div: restoring divider, one quotient bit per cycle
// 64-bit unsigned quotient after 64 steps; divisor must be nonzero.
// ----------------------------------------------------------------------------
`default_nettype none

module rau_div (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [63:0]   dividend_i,
  input  wire logic [63:0]   divisor_i,
  output rau_pkg::unit_sts_t sts_o,
  output logic      [63:0]   quo_o
);

  logic        busy_q, busy_d, done_q, done_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [63:0] rem_q, rem_d, quo_q, quo_d, dvs_q, dvs_d;
  logic [64:0] trial;
  logic        fits;

  assign trial = {rem_q, quo_q[63]};
  assign fits  = trial >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (start_i && !busy_q) begin
      busy_d = 1'b1;
      cnt_d  = 6'd0;
      rem_d  = 64'd0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = fits ? 64'(trial - {1'b0, dvs_q}) : trial[63:0];
      quo_d = {quo_q[62:0], fits};
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd63) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign quo_o      = quo_q;

endmodule

`default_nettype wire

FILE: rtl/rational_arith_unit.sv
// ----------------------------------------------------------------------------
// rational_arith_unit: exact fraction arithmetic and comparison
// Normalizes two fractions, applies the opcode, reduces fraction results by the gcd.
// ----------------------------------------------------------------------------
// One request at a time. A request forms three products on the shared
// multiplier, takes one combine step, runs the binary gcd (one shift or
// subtract per cycle) and two restoring divisions of numerator and
// denominator by the gcd. Comparisons, zero denominators, division by zero
// and unused opcodes skip gcd and division and go from the combine step to
// the output. Stall is high from acceptance until the result has been taken.
`default_nettype none

module rational_arith_unit #(
  parameter int WIDTH = rau_pkg::DefWidth
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_stall_o,
  input  wire rau_pkg::in_t in_i,
  output logic              out_valid_o,
  input  wire logic         out_stall_i,
  output rau_pkg::out_t     out_o
);

  localparam int OPW = (WIDTH < 32) ? WIDTH : 32;
  localparam int SH  = 32 - OPW;
  localparam logic [63:0] HALF = 64'd1 << (OPW - 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_SUM  = 3'd2;
  localparam logic [2:0] S_GCD  = 3'd3;
  localparam logic [2:0] S_DIVN = 3'd4;
  localparam logic [2:0] S_DIVD = 3'd5;
  localparam logic [2:0] S_CHK  = 3'd6;
  localparam logic [2:0] S_OUT  = 3'd7;

  logic [2:0] state_q, state_d;
  logic [1:0] cnt_q, cnt_d;

  // sign extension from the operand width
  logic signed [31:0] an_s, ad_s, bn_s, bd_s;
  logic signed [31:0] an_t, ad_t, bn_t, bd_t;
  assign an_t = in_i.a_num <<< SH;
  assign ad_t = in_i.a_den <<< SH;
  assign bn_t = in_i.b_num <<< SH;
  assign bd_t = in_i.b_den <<< SH;
  assign an_s = an_t >>> SH;
  assign ad_s = ad_t >>> SH;
  assign bn_s = bn_t >>> SH;
  assign bd_s = bd_t >>> SH;

  logic [31:0] an_m, ad_m, bn_m, bd_m;
  assign an_m = an_s[31] ? 32'(-an_s) : an_s;
  assign ad_m = ad_s[31] ? 32'(-ad_s) : ad_s;
  assign bn_m = bn_s[31] ? 32'(-bn_s) : bn_s;
  assign bd_m = bd_s[31] ? 32'(-bd_s) : bd_s;

  logic [3:0]  op_q;
  logic        zden_q, an_neg_q, bn_neg_q;
  logic [31:0] an_q, ad_q, bn_q, bd_q;
  logic [63:0] m_q [3];
  logic        num_neg_q, num_neg_d;
  logic [63:0] num_q, num_d, den_q, g_q, numr_q;
  rau_pkg::out_t out_q, out_d;

  // multiplier operand schedule
  logic [31:0] mx, my;
  logic [63:0] p;
  always_comb begin
    mx = an_q;
    my = bd_q;
    case (cnt_q)
      2'd0: begin
        case (op_q)
          rau_pkg::OP_MUL: my = bn_q;
          rau_pkg::OP_NEG: my = 32'd1;
          rau_pkg::OP_REC: begin
            mx = ad_q;
            my = 32'd1;
          end
          default: ;
        endcase
      end
      2'd1: begin
        mx = bn_q;
        my = ad_q;
      end
      default: begin
        mx = ad_q;
        case (op_q)
          rau_pkg::OP_DIV: my = bn_q;
          rau_pkg::OP_NEG: my = 32'd1;
          rau_pkg::OP_REC: begin
            mx = an_q;
            my = 32'd1;
          end
          default: ;
        endcase
      end
    endcase
  end

  rau_mul u_mul (.clk_i(clk_i), .a_i(mx), .b_i(my), .p_o(p));

  // combine and compare
  logic s0n, s1n, m1z, cmp_lt, cmp_eq, cmp_r, frac;
  logic [1:0] st_sum;
  always_comb begin
    m1z = (m_q[1] == 64'd0);
    s0n = an_neg_q;
    s1n = bn_neg_q ^ ((op_q == rau_pkg::OP_SUB) && !m1z);
    num_d = m_q[0];
    num_neg_d = 1'b0;
    case (op_q)
      rau_pkg::OP_ADD, rau_pkg::OP_SUB: begin
        if (s0n == s1n) begin
          num_d = m_q[0] + m_q[1];
          num_neg_d = s0n;
        end else if (m_q[0] >= m_q[1]) begin
          num_d = m_q[0] - m_q[1];
          num_neg_d = s0n;
        end else begin
          num_d = m_q[1] - m_q[0];
          num_neg_d = s1n;
        end
      end
      rau_pkg::OP_MUL, rau_pkg::OP_DIV: num_neg_d = an_neg_q ^ bn_neg_q;
      rau_pkg::OP_NEG: num_neg_d = !an_neg_q;
      rau_pkg::OP_REC: num_neg_d = an_neg_q;
      default: ;
    endcase
    if (num_d == 64'd0) num_neg_d = 1'b0;

    cmp_eq = (an_neg_q == bn_neg_q) && (m_q[0] == m_q[1]);
    if (an_neg_q != bn_neg_q) cmp_lt = an_neg_q;
    else if (an_neg_q) cmp_lt = m_q[0] > m_q[1];
    else cmp_lt = m_q[0] < m_q[1];
    case (op_q)
      rau_pkg::OP_EQ: cmp_r = cmp_eq;
      rau_pkg::OP_LT: cmp_r = cmp_lt;
      rau_pkg::OP_LE: cmp_r = cmp_lt || cmp_eq;
      rau_pkg::OP_GT: cmp_r = !cmp_lt && !cmp_eq;
      rau_pkg::OP_GE: cmp_r = !cmp_lt;
      default:        cmp_r = 1'b0;
    endcase

    frac   = 1'b0;
    st_sum = rau_pkg::ST_OK;
    if (zden_q) begin
      st_sum = rau_pkg::ST_DIVZ;
      cmp_r  = 1'b0;
    end else if ((op_q == rau_pkg::OP_DIV && bn_q == 32'd0) ||
                 (op_q == rau_pkg::OP_REC && an_q == 32'd0)) begin
      st_sum = rau_pkg::ST_DIVZ;
    end else if (op_q inside {rau_pkg::OP_ADD, rau_pkg::OP_SUB, rau_pkg::OP_MUL,
                              rau_pkg::OP_DIV, rau_pkg::OP_NEG, rau_pkg::OP_REC}) begin
      frac = 1'b1;
    end
  end

  // gcd and exact division
  rau_pkg::unit_sts_t gcd_sts, div_sts;
  logic [63:0] g, quo;
  logic        gcd_go, div_go;
  logic [63:0] div_a, div_b;

  assign gcd_go = (state_q == S_SUM) && frac;
  rau_gcd u_gcd (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(gcd_go),
    .x_i(num_d), .y_i(m_q[2]), .sts_o(gcd_sts), .g_o(g)
  );

  always_comb begin
    div_go = 1'b0;
    div_a  = num_q;
    div_b  = g;
    if (state_q == S_GCD && gcd_sts.done) begin
      div_go = 1'b1;
    end else if (state_q == S_DIVN && div_sts.done) begin
      div_go = 1'b1;
      div_a  = den_q;
      div_b  = g_q;
    end
  end

  rau_div u_div (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(div_go),
    .dividend_i(div_a), .divisor_i(div_b), .sts_o(div_sts), .quo_o(quo)
  );

  // overflow check and final result
  logic        ovf;
  logic [63:0] onum;
  assign ovf  = (quo > HALF - 64'd1) ||
                (numr_q > (num_neg_q ? HALF : HALF - 64'd1));
  assign onum = num_neg_q ? 64'(-numr_q) : numr_q;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    out_d   = out_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_MUL;
          cnt_d   = 2'd0;
        end
      end
      S_MUL: begin
        cnt_d = cnt_q + 2'd1;
        if (cnt_q == 2'd3) state_d = S_SUM;
      end
      S_SUM: begin
        out_d.res_num  = '0;
        out_d.res_den  = 31'd1;
        out_d.cmp_true = cmp_r;
        out_d.status   = st_sum;
        state_d = frac ? S_GCD : S_OUT;
      end
      S_GCD: if (gcd_sts.done) state_d = S_DIVN;
      S_DIVN: if (div_sts.done) state_d = S_DIVD;
      S_DIVD: if (div_sts.done) state_d = S_CHK;
      S_CHK: begin
        if (ovf) begin
          out_d.status = rau_pkg::ST_OVF;
        end else begin
          out_d.res_num = onum[31:0];
          out_d.res_den = quo[30:0];
        end
        state_d = S_OUT;
      end
      S_OUT: if (!out_stall_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= 2'd0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (state_q == S_IDLE) begin
      op_q     <= in_i.opcode;
      zden_q   <= (ad_s == 32'sd0) || (bd_s == 32'sd0);
      an_q     <= an_m;
      ad_q     <= ad_m;
      bn_q     <= bn_m;
      bd_q     <= bd_m;
      an_neg_q <= (an_s[31] ^ ad_s[31]) && (an_m != 32'd0);
      bn_neg_q <= (bn_s[31] ^ bd_s[31]) && (bn_m != 32'd0);
    end
    if (state_q == S_MUL && cnt_q != 2'd0) m_q[cnt_q - 2'd1] <= p;
    if (state_q == S_SUM) begin
      num_q     <= num_d;
      num_neg_q <= num_neg_d;
      den_q     <= m_q[2];
    end
    if (state_q == S_GCD && gcd_sts.done) g_q <= g;
    if (state_q == S_DIVN && div_sts.done) numr_q <= quo;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign out_o       = out_q;

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.status != rau_pkg::ST_OK |->
      out_o.res_num == 32'sd0 && out_o.res_den == 31'd1 && !out_o.cmp_true)
    else $error("error result not 0/1");

  a_cmp_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.cmp_true |->
      out_o.status == rau_pkg::ST_OK && out_o.res_num == 32'sd0)
    else $error("compare result with fraction or error");

  a_den_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_o.res_den != 31'd0)
    else $error("zero result denominator");

  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> !out_valid_o)
    else $error("result right after request");

endmodule

`default_nettype wire
